[hdl/fba_pkg.sv]
`timescale 1ns / 1ps

package fba_pkg;

    // Frame space
    localparam int MAX_FRAMES = 4096;
    localparam int WORD_BITS  = 32;
    localparam int MAP_WORDS  = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int IDX_W      = $clog2(MAP_WORDS);
    localparam int FRAME_W    = 12;
    localparam int COUNT_W    = 13;

    localparam logic [COUNT_W-1:0] MAX_COUNT   = COUNT_W'(MAX_FRAMES);
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(4096);

    // Request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_NOP     = 2'd1;
    localparam logic [1:0] STAT_NO_FREE = 2'd2;

    // Register map (index = paddr[2])
    localparam int  APB_ADDR_W     = 3;
    localparam logic REG_FRAME_COUNT = 1'b0;

    typedef struct packed {
        logic               mode;
        logic [FRAME_W-1:0] current_frame;
        logic               kernel_page;
        logic               want_write;
    } fba_in_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_number;
        logic               present;
        logic               writable;
        logic               user_mode;
        logic [1:0]         status;
    } fba_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FREE
    } fba_state_t;

endpackage

[hdl/frame_bitmap_allocator_core.sv]
`timescale 1ns / 1ps

// First-fit physical frame allocator over a used-frame bitmap (128 words x 32
// bits, one bit per frame, all free after reset). Pulse start with a command
// word while busy is low. Allocate (mode 0, current_frame 0) scans the bitmap
// from word 0 up, one word per clock through a single read port, and takes
// the lowest free frame below frame_count; the result is strobed on done the
// cycle after the scan ends. Free (mode 1) is a read-modify-write of one word,
// read on accept and written back in ST_FREE, with done registered after it.
// Requests with nothing to do (allocate with a frame already held,
// free of frame 0) answer the cycle after accept without going busy. done is
// high for exactly one cycle and the receiver cannot stall it; capture the
// result word on that cycle. frame_count is set over APB at address 0 and
// must only be written while no request is in flight.
module frame_bitmap_allocator_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  fba_pkg::fba_in_t                 cmd,
    output logic                             done,
    output fba_pkg::fba_out_t                result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fba_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import fba_pkg::*;

    // control state
    fba_state_t           state_reg, state_next;
    logic [IDX_W-1:0]     chk_idx_reg, chk_idx_next;
    logic [FRAME_W-1:0]   cur_reg;
    logic                 kern_reg;
    logic                 wr_reg;
    logic [COUNT_W-1:0]   frame_count_reg;
    logic [MAP_WORDS-1:0] valid_reg;
    logic                 done_reg, done_next;
    fba_out_t             res_reg, res_next;

    // bitmap memory, registered read
    logic [WORD_BITS-1:0] mem [0:MAP_WORDS-1];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_valid_reg;
    logic [IDX_W-1:0]     mem_raddr;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    logic                 accept;
    logic                 cfg_wr;
    logic [COUNT_W-1:0]   limit;
    logic [WORD_BITS-1:0] word_eff;
    logic                 word_full;
    logic [BIT_W-1:0]     zero_pos;
    logic [COUNT_W-1:0]   base;
    logic [COUNT_W-1:0]   cand;
    logic                 scan_hit;
    logic                 scan_fail;
    logic [BIT_W-1:0]     free_bit;

    assign accept   = start && (state_reg == ST_IDLE);
    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign result   = res_reg;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_FRAME_COUNT) ?
                      {{(32-COUNT_W){1'b0}}, frame_count_reg} : 32'd0;

    // counts above the bitmap size clamp to it
    assign limit    = (frame_count_reg > MAX_COUNT) ? MAX_COUNT : frame_count_reg;

    // never-written words read as all free
    assign word_eff  = rd_valid_reg ? rd_data_reg : '0;
    assign word_full = (word_eff == '1);
    assign base      = {1'b0, chk_idx_reg, {BIT_W{1'b0}}};
    assign cand      = {1'b0, chk_idx_reg, zero_pos};
    assign free_bit  = cur_reg[BIT_W-1:0];

    // lowest clear bit of the word under test
    always_comb
    begin
        zero_pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!word_eff[i])
            begin
                zero_pos = BIT_W'(i);
            end
        end
    end

    // scan verdict for the word arriving this cycle
    always_comb
    begin
        scan_hit  = 1'b0;
        scan_fail = 1'b0;
        if (base >= limit)
        begin
            scan_fail = 1'b1;
        end
        else if (word_full)
        begin
            scan_fail = (chk_idx_reg == IDX_W'(MAP_WORDS - 1));
        end
        else if (cand >= limit)
        begin
            scan_fail = 1'b1;
        end
        else
        begin
            scan_hit = 1'b1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.mode == MODE_FREE && cmd.current_frame != '0)
                    begin
                        state_next = ST_FREE;
                    end
                    else if (cmd.mode == MODE_ALLOC && cmd.current_frame == '0)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_hit || scan_fail)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FREE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        chk_idx_next = chk_idx_reg;
        done_next    = 1'b0;
        res_next     = '0;
        mem_raddr    = '0;
        mem_we       = 1'b0;
        mem_waddr    = chk_idx_reg;
        mem_wdata    = word_eff;
        unique case (state_reg)
            ST_IDLE:
            begin
                chk_idx_next = '0;
                if (accept)
                begin
                    if (cmd.mode == MODE_FREE)
                    begin
                        mem_raddr = cmd.current_frame[FRAME_W-1:BIT_W];
                        if (cmd.current_frame == '0)
                        begin
                            done_next       = 1'b1;
                            res_next.status = STAT_NOP;
                        end
                    end
                    else if (cmd.current_frame != '0)
                    begin
                        done_next       = 1'b1;
                        res_next.status = STAT_NOP;
                    end
                end
            end
            ST_SCAN:
            begin
                // read one word ahead while testing the current one
                mem_raddr    = chk_idx_reg + IDX_W'(1);
                chk_idx_next = chk_idx_reg + IDX_W'(1);
                if (scan_hit)
                begin
                    mem_we                = 1'b1;
                    mem_wdata             = word_eff | (WORD_BITS'(1) << zero_pos);
                    done_next             = 1'b1;
                    res_next.frame_number = cand[FRAME_W-1:0];
                    res_next.present      = 1'b1;
                    res_next.writable     = wr_reg;
                    res_next.user_mode    = ~kern_reg;
                    res_next.status       = STAT_DONE;
                end
                else if (scan_fail)
                begin
                    done_next       = 1'b1;
                    res_next.status = STAT_NO_FREE;
                end
            end
            ST_FREE:
            begin
                mem_we          = 1'b1;
                mem_waddr       = cur_reg[FRAME_W-1:BIT_W];
                mem_wdata       = word_eff & ~(WORD_BITS'(1) << free_bit);
                done_next       = 1'b1;
                res_next.status = STAT_DONE;
            end
            default:
            begin
                chk_idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            chk_idx_reg     <= '0;
            frame_count_reg <= COUNT_RESET;
            valid_reg       <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            chk_idx_reg <= chk_idx_next;
            done_reg    <= done_next;
            if (cfg_wr && paddr[2] == REG_FRAME_COUNT)
            begin
                frame_count_reg <= pwdata[COUNT_W-1:0];
            end
            if (mem_we)
            begin
                valid_reg[mem_waddr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_reg      <= res_next;
        rd_valid_reg <= valid_reg[mem_raddr];
        if (accept)
        begin
            cur_reg  <= cmd.current_frame;
            kern_reg <= cmd.kernel_page;
            wr_reg   <= cmd.want_write;
        end
    end

    // bitmap memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

// Self-checking bench for frame_bitmap_allocator_core.
// A directed plan runs first, then random traffic over a series of frame_count
// settings. Every accepted command word is run through a local model of the
// used-frame bitmap. The matching result word is queued and compared, field by
// field, on the done strobe.
module tb_top;
    import fba_pkg::*;

    // Run shape
    localparam int ITEMS_PER_PHASE = 36;
    localparam int N_PHASES        = 12;
    localparam int WATCHDOG_LIMIT  = 4000;   // quiet cycles
    localparam int DRAIN_CYCLES    = 160;
    localparam int MAX_PRINTED     = 40;

    localparam logic [APB_ADDR_W-1:0] FRAME_COUNT_ADDR =
        APB_ADDR_W'({REG_FRAME_COUNT, 2'b00});

    // Counts walked by the random phases: odd sizes, word edges, zero, one,
    // the maximum, and values past it that clamp to MAX_FRAMES.
    localparam int PHASE_COUNT [N_PHASES] =
        '{40, 33, 32, 31, 64, 1, 8191, 4096, 0, 100, 7, 4097};

    // One row of the directed plan: a register write or a command word,
    // the latter with a hand-written result where it is obvious.
    typedef struct packed {
        logic               is_cfg;
        logic [COUNT_W-1:0] cfg_value;
        fba_in_t            word;
        logic               typed;
        fba_out_t           want;
    } plan_row_t;

    localparam fba_out_t R_NOP     = '{12'h000, 1'b0, 1'b0, 1'b0, STAT_NOP};
    localparam fba_out_t R_FREED   = '{12'h000, 1'b0, 1'b0, 1'b0, STAT_DONE};
    localparam fba_out_t R_NO_FREE = '{12'h000, 1'b0, 1'b0, 1'b0, STAT_NO_FREE};
    localparam fba_out_t R_ANY     = '0;

    localparam int PLAN_LEN = 25;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        // Reset count 4096; frame zero is handed out like any other
        '{1'b0, 13'd0, '{MODE_ALLOC, 12'h000, 1'b0, 1'b1}, 1'b1,
          '{12'h000, 1'b1, 1'b1, 1'b1, STAT_DONE}},
        '{1'b0, 13'd0, '{MODE_ALLOC, 12'h000, 1'b1, 1'b0}, 1'b1,
          '{12'h001, 1'b1, 1'b0, 1'b0, STAT_DONE}},
        // Page already holds a frame
        '{1'b0, 13'd0, '{MODE_ALLOC, 12'hFFF, 1'b1, 1'b1}, 1'b1, R_NOP},
        '{1'b0, 13'd0, '{MODE_ALLOC, 12'h001, 1'b0, 1'b0}, 1'b1, R_NOP},
        // Free of frame zero does nothing
        '{1'b0, 13'd0, '{MODE_FREE,  12'h000, 1'b1, 1'b1}, 1'b1, R_NOP},
        '{1'b0, 13'd0, '{MODE_FREE,  12'h001, 1'b0, 1'b0}, 1'b1, R_FREED},
        '{1'b0, 13'd0, '{MODE_ALLOC, 12'h000, 1'b1, 1'b1}, 1'b0, R_ANY},
        // Freeing frames that were never used is harmless
        '{1'b0, 13'd0, '{MODE_FREE,  12'hFFF, 1'b1, 1'b1}, 1'b1, R_FREED},
        '{1'b0, 13'd0, '{MODE_FREE,  12'h800, 1'b0, 1'b1}, 1'b1, R_FREED},
        '{1'b0, 13'd0, '{MODE_ALLOC, 12'h000, 1'b0, 1'b0}, 1'b0, R_ANY},
        // Zero frames managed
        '{1'b1, 13'd0,    '0, 1'b0, R_ANY},
        '{1'b0, 13'd0, '{MODE_ALLOC, 12'h000, 1'b0, 1'b1}, 1'b1, R_NO_FREE},
        '{1'b0, 13'd0, '{MODE_FREE,  12'h002, 1'b1, 1'b0}, 1'b1, R_FREED},
        // One frame, and it is frame zero, which can never be freed
        '{1'b1, 13'd1,    '0, 1'b0, R_ANY},
        '{1'b0, 13'd0, '{MODE_ALLOC, 12'h000, 1'b1, 1'b1}, 1'b1, R_NO_FREE},
        '{1'b1, 13'd3,    '0, 1'b0, R_ANY},
        '{1'b0, 13'd0, '{MODE_ALLOC, 12'h000, 1'b0, 1'b1}, 1'b0, R_ANY},
        '{1'b0, 13'd0, '{MODE_ALLOC, 12'h000, 1'b1, 1'b0}, 1'b1, R_NO_FREE},
        // Count above MAX_FRAMES clamps
        '{1'b1, 13'd8191, '0, 1'b0, R_ANY},
        '{1'b0, 13'd0, '{MODE_ALLOC, 12'h000, 1'b1, 1'b1}, 1'b0, R_ANY},
        '{1'b1, 13'd4096, '0, 1'b0, R_ANY},
        '{1'b0, 13'd0, '{MODE_FREE,  12'h003, 1'b0, 1'b0}, 1'b1, R_FREED},
        '{1'b0, 13'd0, '{MODE_ALLOC, 12'h555, 1'b0, 1'b1}, 1'b1, R_NOP},
        '{1'b0, 13'd0, '{MODE_FREE,  12'hAAA, 1'b1, 1'b0}, 1'b1, R_FREED},
        '{1'b0, 13'd0, '{MODE_ALLOC, 12'h000, 1'b0, 1'b0}, 1'b0, R_ANY}
    };

    // DUT ports
    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    fba_in_t           cmd;
    logic              done;
    fba_out_t          result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    frame_bitmap_allocator_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Local copy of the allocator state
    logic [WORD_BITS-1:0] frame_used [MAP_WORDS];
    logic [COUNT_W-1:0]   frame_limit;

    fba_out_t  pending_results [$];   // result words owed by the DUT, oldest first
    int        held_frames [$];       // frames believed allocated, targets for frees

    int        errors;
    int        burst_left;
    int        quiet_cycles;
    int        n_words;
    int        n_granted;
    int        n_refused;
    int        n_nop;
    int        n_freed;
    int        n_cfg;
    int        n_checked;
    fba_out_t  oldest;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic flag(string msg);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    // First fit over the local bitmap, or a bit clear for frees; updates state like the block does.
    function automatic fba_out_t allocate_or_free(fba_in_t w);
        fba_out_t r;
        int       lim;
        int       found;
        r     = '0;
        found = -1;
        if (w.mode == MODE_FREE)
        begin
            if (w.current_frame == '0)
            begin
                r.status = STAT_NOP;
            end
            else
            begin
                frame_used[w.current_frame / WORD_BITS][w.current_frame % WORD_BITS] = 1'b0;
                r.status = STAT_DONE;
            end
            return r;
        end
        if (w.current_frame != '0)
        begin
            r.status = STAT_NOP;
            return r;
        end
        lim = (frame_limit > MAX_COUNT) ? MAX_FRAMES : int'(frame_limit);
        for (int i = 0; i < lim; i++)
        begin
            if (!frame_used[i / WORD_BITS][i % WORD_BITS])
            begin
                found = i;
                break;
            end
        end
        if (found < 0)
        begin
            r.status = STAT_NO_FREE;
            return r;
        end
        frame_used[found / WORD_BITS][found % WORD_BITS] = 1'b1;
        r.frame_number = FRAME_W'(found);
        r.present      = 1'b1;
        r.writable     = w.want_write;
        r.user_mode    = ~w.kernel_page;
        r.status       = STAT_DONE;
        return r;
    endfunction

    // Mostly well-formed traffic: allocations and frees of held frames,
    // with frees of arbitrary frames and allocations for pages that
    // already own one mixed in.
    function automatic fba_in_t random_word();
        fba_in_t w;
        int      pick;
        pick          = $urandom_range(0, 99);
        w.kernel_page = 1'($urandom);
        w.want_write  = 1'($urandom);
        if (pick < 50)
        begin
            w.mode          = MODE_ALLOC;
            w.current_frame = '0;
        end
        else if (pick < 80 && held_frames.size() != 0)
        begin
            w.mode          = MODE_FREE;
            w.current_frame =
                FRAME_W'(held_frames[$urandom_range(0, held_frames.size() - 1)]);
        end
        else if (pick < 92)
        begin
            w.mode          = MODE_FREE;
            w.current_frame = FRAME_W'($urandom);
        end
        else
        begin
            w.mode          = MODE_ALLOC;
            w.current_frame = FRAME_W'($urandom_range(1, 4095));
        end
        return w;
    endfunction

    // Sender pacing: bursts of random length, random gaps between them.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Present one command word, wait for the accept edge, then queue what
    // the result word must be: the typed one if given, else the model's.
    task automatic issue_word(fba_in_t w, logic typed, fba_out_t want);
        fba_out_t predicted;
        start <= 1'b1;
        cmd   <= w;
        @(posedge clk);
        while (busy) @(posedge clk);
        predicted = allocate_or_free(w);
        n_words++;
        if (w.mode == MODE_FREE)
        begin
            for (int k = held_frames.size() - 1; k >= 0; k--)
                if (held_frames[k] == int'(w.current_frame))
                    held_frames.delete(k);
        end
        if (predicted.present && predicted.frame_number != '0)
            held_frames.push_back(int'(predicted.frame_number));
        case (predicted.status)
            STAT_NOP:     n_nop++;
            STAT_NO_FREE: n_refused++;
            default:      if (predicted.present) n_granted++; else n_freed++;
        endcase
        pending_results.push_back(typed ? want : predicted);
    endtask

    // frame_count write, only with nothing in flight, followed by a readback.
    task automatic set_frame_count(logic [COUNT_W-1:0] value);
        start <= 1'b0;
        while (pending_results.size() != 0 || busy) @(posedge clk);
        repeat (3) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FRAME_COUNT_ADDR;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        frame_limit = value;
        n_cfg++;
        // back-to-back read of the same register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== 32'(value))
            flag($sformatf("frame_count readback %0d, wrote %0d", prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Result checker and watchdog. done is sampled at the edge that ends its
    // cycle; the receiver has no way to stall it.
    always @(posedge clk)
    begin
        if (done)
        begin
            n_checked++;
            if (pending_results.size() == 0)
            begin
                flag($sformatf("result word with nothing expected: %h", result));
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (result.frame_number !== oldest.frame_number)
                    flag($sformatf("frame_number %0d, want %0d",
                                   result.frame_number, oldest.frame_number));
                if (result.present !== oldest.present)
                    flag($sformatf("present %b, want %b", result.present, oldest.present));
                if (result.writable !== oldest.writable)
                    flag($sformatf("writable %b, want %b", result.writable, oldest.writable));
                if (result.user_mode !== oldest.user_mode)
                    flag($sformatf("user_mode %b, want %b",
                                   result.user_mode, oldest.user_mode));
                if (result.status !== oldest.status)
                    flag($sformatf("status %0d, want %0d", result.status, oldest.status));
            end
        end
        if (!rst_n || done || (start && !busy) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_results.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        plan_row_t row;
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        errors       = 0;
        burst_left   = 0;
        quiet_cycles = 0;
        n_words      = 0;
        n_granted    = 0;
        n_refused    = 0;
        n_nop        = 0;
        n_freed      = 0;
        n_cfg        = 0;
        n_checked    = 0;
        frame_limit  = COUNT_RESET;
        foreach (frame_used[i])
            frame_used[i] = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed plan
        for (int r = 0; r < PLAN_LEN; r++)
        begin
            row = PLAN[r];
            if (row.is_cfg)
            begin
                set_frame_count(row.cfg_value);
            end
            else
            begin
                pace_sender();
                issue_word(row.word, row.typed, row.want);
            end
        end

        // Random phases, one frame_count setting each; the bitmap carries over
        for (int p = 0; p < N_PHASES; p++)
        begin
            set_frame_count(COUNT_W'(PHASE_COUNT[p]));
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pace_sender();
                issue_word(random_word(), 1'b0, R_ANY);
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d command words: %0d frames granted, %0d refused,",
                 n_words, n_granted, n_refused);
        $display("%0d no-ops, %0d frees, %0d frame_count settings, %0d results checked",
                 n_nop, n_freed, n_cfg, n_checked);
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
